// ===== rtl/g2c_pkg.sv =====
// ----------------------------------------------------------------------------
// g2c_pkg
// Types, constants and elaboration-time functions shared by the geodetic to
// Cartesian conversion pipeline.
// ----------------------------------------------------------------------------
package g2c_pkg;

  localparam int CordicStagesDef = 32;
  localparam int WordW           = 64;
  localparam int AxisW           = 34;
  localparam int AngleW          = 32;
  localparam int DistW           = 32;
  localparam int CoordW          = 36;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic {
    REG_SEMI_MAJOR = 1'b0,
    REG_SEMI_MINOR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] coord;
    logic                     sat;
  } coord_t;

  localparam logic [AxisW-1:0] SemiMajorRst = 34'd6378137000;
  localparam logic [AxisW-1:0] SemiMinorRst = 34'd6356752314;

  localparam word_t PiQ60        = 64'sh3243F6A8885A308D;
  localparam word_t HalfPiQ60    = 64'sh1921FB54442D1846;
  localparam word_t QuarterPiQ60 = 64'sh0C90FDAA22168C23;
  localparam word_t OneQ61       = 64'sh2000000000000000;
  localparam word_t KSeed        = (OneQ61 / 5) * 3;
  localparam word_t Int64Max     = 64'sh7FFFFFFFFFFFFFFF;
  localparam word_t RoundHalfQ16 = 64'sd32768;

  localparam logic signed [CoordW-1:0] CoordMax = 36'sh7FFFFFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 36'sh800000000;

  // Unsigned long division by shift and subtract, used for constants only.
  function automatic logic [WordW-1:0] const_udiv(logic [WordW-1:0] num,
                                                   logic [WordW-1:0] den);
    logic [WordW-1:0] quo;
    logic [WordW:0]   rem;
    quo = '0;
    rem = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      rem = {rem[WordW-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q60 from the alternating series.
  function automatic word_t atan_stage(int i);
    word_t sum;
    word_t t;
    int    e;
    if (i == 0) begin
      return QuarterPiQ60;
    end
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        t = word_t'(const_udiv(64'd1 << (60 - e), 64'(2 * k + 1)));
        sum = (k % 2 == 1) ? sum - t : sum + t;
      end
    end
    return sum;
  endfunction

  // Rounded, saturating product shift for constant evaluation.
  function automatic word_t const_mul_shift(word_t p, word_t q, int s);
    logic signed [2*WordW-1:0] prod;
    logic [2*WordW-1:0]        mag;
    logic                      neg;
    prod = $signed({{WordW{p[WordW-1]}}, p}) * $signed({{WordW{q[WordW-1]}}, q});
    neg  = p[WordW-1] ^ q[WordW-1];
    mag  = prod[2*WordW-1] ? -prod : prod;
    mag  = (mag + (128'd1 << (s - 1))) >> s;
    if (mag > 128'(Int64Max)) begin
      mag = 128'(Int64Max);
    end
    return neg ? -word_t'(mag[WordW-1:0]) : word_t'(mag[WordW-1:0]);
  endfunction

  // Inverse CORDIC gain in Q61 for the given number of iterations.
  function automatic word_t gain_inverse(int stages);
    word_t p;
    word_t k;
    word_t t;
    p = OneQ61;
    k = KSeed;
    for (int i = 0; i < stages; i++) begin
      if (2 * i <= 62) begin
        p = p + (p >>> (2 * i));
      end
    end
    for (int n = 0; n < 6; n++) begin
      t = const_mul_shift(k, k, 61);
      t = const_mul_shift(p, t, 61);
      k = const_mul_shift(k, 3 * OneQ61 - t, 62);
    end
    return k;
  endfunction

  // Round a Q16 millimetre value and clamp it to the coordinate range.
  function automatic coord_t finish_coord(word_t q16);
    word_t  v;
    coord_t r;
    v = (q16 + RoundHalfQ16) >>> 16;
    r.sat = 1'b0;
    if (v > word_t'(CoordMax)) begin
      r.coord = CoordMax;
      r.sat   = 1'b1;
    end else if (v < word_t'(CoordMin)) begin
      r.coord = CoordMin;
      r.sat   = 1'b1;
    end else begin
      r.coord = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/g2c_in_if.sv =====
// ----------------------------------------------------------------------------
// g2c_in_if
// Input channel: one geodetic point per word.
// ----------------------------------------------------------------------------
interface g2c_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [31:0] altitude;

  modport source (output valid, latitude, longitude, altitude, input ready);
  modport sink   (input valid, latitude, longitude, altitude, output ready);
endinterface

// ===== rtl/g2c_out_if.sv =====
// ----------------------------------------------------------------------------
// g2c_out_if
// Output channel: one Cartesian point per word.
// ----------------------------------------------------------------------------
interface g2c_out_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] coord_x;
  logic signed [35:0] coord_y;
  logic signed [35:0] coord_z;
  logic               saturated;

  modport source (output valid, coord_x, coord_y, coord_z, saturated, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, saturated, output ready);
endinterface

// ===== rtl/geodetic_to_cartesian_unit.sv =====
// The path from input word to output word runs through three chained CORDIC
// pipelines and four four-stage multipliers. Throughput: one word per cycle;
// the whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and loads the default ellipsoid axes.
// ----------------------------------------------------------------------------
// geodetic_to_cartesian_unit
// Converts latitude, longitude and altitude to earth-centered Cartesian
// coordinates on a configurable ellipsoid.
// ----------------------------------------------------------------------------
module geodetic_to_cartesian_unit #(
  parameter int CORDIC_STAGES = g2c_pkg::CordicStagesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [g2c_pkg::AxisW-1:0]  cfg_data_i,
  g2c_in_if.sink                     in_i,
  g2c_out_if.source                  out_o
);
  import g2c_pkg::*;

  localparam word_t KQ61 = gain_inverse(CORDIC_STAGES);
  localparam word_t XInit = KQ61 <<< 1;
  localparam int SideW  = DistW + 4 * WordW;

  logic [AxisW-1:0] major_q;
  logic [AxisW-1:0] minor_q;
  word_t            major_w;
  word_t            minor_w;
  logic             en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= SemiMajorRst;
      minor_q <= SemiMinorRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SEMI_MAJOR: major_q <= cfg_data_i;
        REG_SEMI_MINOR: minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign major_w = word_t'({30'd0, major_q});
  assign minor_w = word_t'({30'd0, minor_q});

  // Stage 1: angles to Q60 radians.
  word_t            m1_a [2];
  word_t            m1_b [2];
  word_t            m1_p [2];
  logic             m1_v;
  logic [DistW-1:0] m1_alt;

  assign m1_a[0] = word_t'({{32{in_i.latitude[31]}}, in_i.latitude});
  assign m1_a[1] = word_t'({{32{in_i.longitude[31]}}, in_i.longitude});
  assign m1_b[0] = PiQ60;
  assign m1_b[1] = PiQ60;

  g2c_mul #(.LANES(2), .SHIFT(31), .SW(DistW)) u_mul_angle (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .a_i(m1_a), .b_i(m1_b), .side_i(in_i.altitude),
    .valid_o(m1_v), .p_o(m1_p), .side_o(m1_alt)
  );

  // Stage 2: sine and cosine of latitude and longitude.
  word_t            c1_xi [2];
  word_t            c1_yi [2];
  word_t            c1_x  [2];
  word_t            c1_y  [2];
  logic             c1_v;
  logic [DistW-1:0] c1_alt;

  assign c1_xi[0] = XInit;
  assign c1_xi[1] = XInit;
  assign c1_yi[0] = '0;
  assign c1_yi[1] = '0;

  g2c_cordic #(.LANES(2), .STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SW(DistW)) u_rot_ll (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_v),
    .x_i(c1_xi), .y_i(c1_yi), .z_i(m1_p), .side_i(m1_alt),
    .valid_o(c1_v), .x_o(c1_x), .y_o(c1_y), .z_o(), .side_o(c1_alt)
  );

  // Stage 3: scaled ellipse point (a*cos(lat), b*sin(lat)).
  word_t             m2_a [2];
  word_t             m2_b [2];
  word_t             m2_p [2];
  logic              m2_v;
  logic [SideW-1:0]  m2_side;

  assign m2_a[0] = major_w;
  assign m2_a[1] = minor_w;
  assign m2_b[0] = c1_x[0];
  assign m2_b[1] = c1_y[0];

  g2c_mul #(.LANES(2), .SHIFT(36), .SW(SideW)) u_mul_ellipse (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c1_v),
    .a_i(m2_a), .b_i(m2_b),
    .side_i({c1_alt, c1_x[0], c1_y[0], c1_x[1], c1_y[1]}),
    .valid_o(m2_v), .p_o(m2_p), .side_o(m2_side)
  );

  // Stage 4: reduced latitude by vectoring.
  word_t            c2_x  [1];
  word_t            c2_y  [1];
  word_t            c2_z  [1];
  word_t            c2_th [1];
  logic             c2_v;
  logic [SideW-1:0] c2_side;

  assign c2_x[0] = m2_p[0];
  assign c2_y[0] = m2_p[1];
  assign c2_z[0] = '0;

  g2c_cordic #(.LANES(1), .STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SW(SideW)) u_vec_theta (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m2_v),
    .x_i(c2_x), .y_i(c2_y), .z_i(c2_z), .side_i(m2_side),
    .valid_o(c2_v), .x_o(), .y_o(), .z_o(c2_th), .side_o(c2_side)
  );

  // Stage 5: sine and cosine of the reduced latitude.
  word_t            c3_xi [1];
  word_t            c3_yi [1];
  word_t            c3_x  [1];
  word_t            c3_y  [1];
  logic             c3_v;
  logic [SideW-1:0] c3_side;

  assign c3_xi[0] = XInit;
  assign c3_yi[0] = '0;

  g2c_cordic #(.LANES(1), .STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SW(SideW)) u_rot_theta (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c2_v),
    .x_i(c3_xi), .y_i(c3_yi), .z_i(c2_th), .side_i(c2_side),
    .valid_o(c3_v), .x_o(c3_x), .y_o(c3_y), .z_o(), .side_o(c3_side)
  );

  logic [DistW-1:0] s_alt;
  word_t            s_clat;
  word_t            s_slat;
  word_t            s_clon;
  word_t            s_slon;

  assign {s_alt, s_clat, s_slat, s_clon, s_slon} = c3_side;

  // Stage 6: the four distance terms.
  word_t                m3_a [4];
  word_t                m3_b [4];
  word_t                m3_p [4];
  logic                 m3_v;
  logic [2*WordW-1:0]   m3_side;

  assign m3_a[0] = major_w;
  assign m3_a[1] = word_t'({{32{s_alt[DistW-1]}}, s_alt});
  assign m3_a[2] = minor_w;
  assign m3_a[3] = word_t'({{32{s_alt[DistW-1]}}, s_alt});
  assign m3_b[0] = c3_x[0];
  assign m3_b[1] = s_clat;
  assign m3_b[2] = c3_y[0];
  assign m3_b[3] = s_slat;

  g2c_mul #(.LANES(4), .SHIFT(46), .SW(2*WordW)) u_mul_terms (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c3_v),
    .a_i(m3_a), .b_i(m3_b), .side_i({s_clon, s_slon}),
    .valid_o(m3_v), .p_o(m3_p), .side_o(m3_side)
  );

  // Stage 7: radius in the equatorial plane and the z sum.
  logic  sum_v_q;
  word_t r_q;
  word_t zq_q;
  word_t clon_q;
  word_t slon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else if (en) begin
      sum_v_q <= m3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q    <= m3_p[0] + m3_p[1];
      zq_q   <= m3_p[2] + m3_p[3];
      clon_q <= m3_side[2*WordW-1:WordW];
      slon_q <= m3_side[WordW-1:0];
    end
  end

  // Stage 8: project the radius onto x and y.
  word_t m4_a [2];
  word_t m4_b [2];
  word_t m4_p [2];
  logic  m4_v;
  word_t m4_z;

  assign m4_a[0] = r_q;
  assign m4_a[1] = r_q;
  assign m4_b[0] = clon_q;
  assign m4_b[1] = slon_q;

  g2c_mul #(.LANES(2), .SHIFT(62), .SW(WordW)) u_mul_proj (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sum_v_q),
    .a_i(m4_a), .b_i(m4_b), .side_i(zq_q),
    .valid_o(m4_v), .p_o(m4_p), .side_o(m4_z)
  );

  // Stage 9: rounding, clamping and the output register.
  coord_t fx;
  coord_t fy;
  coord_t fz;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] x_q;
  logic signed [CoordW-1:0] y_q;
  logic signed [CoordW-1:0] z_q;
  logic                     sat_q;

  assign fx = finish_coord(m4_p[0]);
  assign fy = finish_coord(m4_p[1]);
  assign fz = finish_coord(m4_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q   <= fx.coord;
      y_q   <= fy.coord;
      z_q   <= fz.coord;
      sat_q <= fx.sat | fy.sat | fz.sat;
    end
  end

  // The pipeline moves whenever the output register can take a word.
  assign en            = !out_valid_q || out_o.ready;
  assign in_i.ready    = en;
  assign out_o.valid   = out_valid_q;
  assign out_o.coord_x = x_q;
  assign out_o.coord_y = y_q;
  assign out_o.coord_z = z_q;
  assign out_o.saturated = sat_q;

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the output word is stalled");

  a_sat_at_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.coord_x == CoordMax || out_o.coord_x == CoordMin ||
       out_o.coord_y == CoordMax || out_o.coord_y == CoordMin ||
       out_o.coord_z == CoordMax || out_o.coord_z == CoordMin))
    else $error("saturated flag set with no coordinate at a bound");

endmodule

// ===== rtl/g2c_mul.sv =====
// ----------------------------------------------------------------------------
// g2c_mul
// Four-stage 64x64 signed multiplier lanes with rounding right shift and
// saturation, built from 32x32 partial products.
// ----------------------------------------------------------------------------
module g2c_mul #(
  parameter int LANES = 1,
  parameter int SHIFT = 31,
  parameter int SW    = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  g2c_pkg::word_t      a_i [LANES],
  input  g2c_pkg::word_t      b_i [LANES],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output g2c_pkg::word_t      p_o [LANES],
  output logic [SW-1:0]       side_o
);
  import g2c_pkg::*;

  localparam int Depth = 4;
  localparam logic [2*WordW-1:0] RoundC = 128'd1 << (SHIFT - 1);

  logic [Depth-1:0] valid_q;
  logic [SW-1:0]    side_q [Depth];

  logic [WordW-1:0]   ma_q  [LANES];
  logic [WordW-1:0]   mb_q  [LANES];
  logic               nega_q[LANES];
  logic [WordW-1:0]   ll_q  [LANES];
  logic [WordW-1:0]   lh_q  [LANES];
  logic [WordW-1:0]   hl_q  [LANES];
  logic [WordW-1:0]   hh_q  [LANES];
  logic               negb_q[LANES];
  logic [2*WordW-1:0] sum_q [LANES];
  logic               negc_q[LANES];
  word_t              p_q   [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int d = 1; d < Depth; d++) begin
        side_q[d] <= side_q[d-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [2*WordW-1:0] shifted;
    logic [WordW-1:0]   mag;

    always_comb begin
      shifted = sum_q[l] >> SHIFT;
      mag     = (shifted > 128'(Int64Max)) ? Int64Max : shifted[WordW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nega_q[l] <= a_i[l][WordW-1] ^ b_i[l][WordW-1];
        ma_q[l]   <= a_i[l][WordW-1] ? 64'(-a_i[l]) : 64'(a_i[l]);
        mb_q[l]   <= b_i[l][WordW-1] ? 64'(-b_i[l]) : 64'(b_i[l]);

        negb_q[l] <= nega_q[l];
        ll_q[l]   <= 64'(ma_q[l][31:0])  * 64'(mb_q[l][31:0]);
        lh_q[l]   <= 64'(ma_q[l][31:0])  * 64'(mb_q[l][63:32]);
        hl_q[l]   <= 64'(ma_q[l][63:32]) * 64'(mb_q[l][31:0]);
        hh_q[l]   <= 64'(ma_q[l][63:32]) * 64'(mb_q[l][63:32]);

        negc_q[l] <= negb_q[l];
        sum_q[l]  <= 128'(ll_q[l]) + (128'(lh_q[l]) << 32) + (128'(hl_q[l]) << 32)
                   + (128'(hh_q[l]) << 64) + RoundC;

        p_q[l]    <= negc_q[l] ? -word_t'(mag) : word_t'(mag);
      end
    end

    assign p_o[l] = p_q[l];
  end

  assign valid_o = valid_q[Depth-1];
  assign side_o  = side_q[Depth-1];

endmodule

// ===== rtl/g2c_cordic.sv =====
// ----------------------------------------------------------------------------
// g2c_cordic
// Pipelined CORDIC, one register stage per iteration, in rotation or
// vectoring mode, with quadrant folding in front and sign restore behind.
// ----------------------------------------------------------------------------
module g2c_cordic #(
  parameter int LANES  = 1,
  parameter int STAGES = 32,
  parameter bit VECTOR = 1'b0,
  parameter int SW     = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  g2c_pkg::word_t      x_i [LANES],
  input  g2c_pkg::word_t      y_i [LANES],
  input  g2c_pkg::word_t      z_i [LANES],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output g2c_pkg::word_t      x_o [LANES],
  output g2c_pkg::word_t      y_o [LANES],
  output g2c_pkg::word_t      z_o [LANES],
  output logic [SW-1:0]       side_o
);
  import g2c_pkg::*;

  localparam int Depth = STAGES + 2;

  logic [Depth-1:0] valid_q;
  logic [SW-1:0]    side_q [Depth];

  word_t x_q    [STAGES+1][LANES];
  word_t y_q    [STAGES+1][LANES];
  word_t z_q    [STAGES+1][LANES];
  logic  flip_q [STAGES+1][LANES];
  word_t xo_q   [LANES];
  word_t yo_q   [LANES];
  word_t zo_q   [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int d = 1; d < Depth; d++) begin
        side_q[d] <= side_q[d-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // Fold the start point so the iterations see a convergent range.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (VECTOR) begin
          flip_q[0][l] <= 1'b0;
          if (x_i[l] < 0) begin
            x_q[0][l] <= -x_i[l];
            y_q[0][l] <= -y_i[l];
            z_q[0][l] <= (y_i[l] >= 0) ? z_i[l] + PiQ60 : z_i[l] - PiQ60;
          end else begin
            x_q[0][l] <= x_i[l];
            y_q[0][l] <= y_i[l];
            z_q[0][l] <= z_i[l];
          end
        end else begin
          x_q[0][l] <= x_i[l];
          y_q[0][l] <= y_i[l];
          if (z_i[l] > HalfPiQ60) begin
            z_q[0][l]    <= z_i[l] - PiQ60;
            flip_q[0][l] <= 1'b1;
          end else if (z_i[l] < -HalfPiQ60) begin
            z_q[0][l]    <= z_i[l] + PiQ60;
            flip_q[0][l] <= 1'b1;
          end else begin
            z_q[0][l]    <= z_i[l];
            flip_q[0][l] <= 1'b0;
          end
        end
      end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_iter
      localparam word_t Atan = atan_stage(s);
      word_t xs;
      word_t ys;
      logic  pos;

      always_comb begin
        xs  = x_q[s][l] >>> s;
        ys  = y_q[s][l] >>> s;
        pos = VECTOR ? (y_q[s][l] < 0) : (z_q[s][l] >= 0);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          flip_q[s+1][l] <= flip_q[s][l];
          if (pos) begin
            x_q[s+1][l] <= x_q[s][l] - ys;
            y_q[s+1][l] <= y_q[s][l] + xs;
            z_q[s+1][l] <= z_q[s][l] - Atan;
          end else begin
            x_q[s+1][l] <= x_q[s][l] + ys;
            y_q[s+1][l] <= y_q[s][l] - xs;
            z_q[s+1][l] <= z_q[s][l] + Atan;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xo_q[l] <= flip_q[STAGES][l] ? -x_q[STAGES][l] : x_q[STAGES][l];
        yo_q[l] <= flip_q[STAGES][l] ? -y_q[STAGES][l] : y_q[STAGES][l];
        zo_q[l] <= z_q[STAGES][l];
      end
    end

    assign x_o[l] = xo_q[l];
    assign y_o[l] = yo_q[l];
    assign z_o[l] = zo_q[l];
  end

  assign valid_o = valid_q[Depth-1];
  assign side_o  = side_q[Depth-1];

endmodule
